### sv/wbps_pkg.sv
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int OFFSET_BITS = 32;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 7;
    localparam int SKIP_W      = 16;
    localparam int DATA_W      = 32;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SCAN = 1'b1
    } t_opcode;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_SKIP_COUNT     = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_opcode          opcode;
        logic [IDX_W-1:0] entry_index;
        logic [7:0]       entry_byte;
        logic             entry_wild;
        logic [7:0]       scan_byte;
        logic             last_byte;
    } t_scan_item;

    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] match_offset;
    } t_scan_result;

    // Broadcast to every cell of the window chain
    typedef struct packed {
        logic             scan;
        logic             clear;
        logic             rotate;
        logic [IDX_W-1:0] len_m1;
        logic [7:0]       feed;
        logic             load;
        logic [IDX_W-1:0] entry_index;
        logic [7:0]       entry_byte;
        logic             entry_wild;
    } t_cell_ctrl;

    // Clamp the programmed length into 1..PATTERN_MAX
    function automatic logic [LEN_W-1:0] active_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(PATTERN_MAX)) begin
            res = LEN_W'(PATTERN_MAX);
        end
        return res;
    endfunction

endpackage

### sv/wbps_cell.sv
`timescale 1ns / 1ps

module wbps_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [wbps_pkg::IDX_W-1:0] i_pos,
    input  wbps_pkg::t_cell_ctrl       i_ctrl,
    input  logic [7:0]                 i_w,
    input  logic [7:0]                 i_a,
    output logic [7:0]                 o_w,
    output logic [7:0]                 o_a,
    output logic                       o_eq
);

    logic [7:0] r_w;
    logic [7:0] r_a;
    logic [7:0] r_pat;
    logic       r_wild;
    logic       tail;
    logic       active;
    logic [7:0] a_src;

    assign tail   = (i_pos == i_ctrl.len_m1);
    assign active = (i_pos <= i_ctrl.len_m1);
    // Aligned byte this cell holds after the shift
    assign a_src  = tail ? i_ctrl.feed : i_a;
    assign o_eq   = !active || r_wild || (r_pat == a_src);
    assign o_w    = r_w;
    assign o_a    = r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
            r_a <= '0;
        end else if (i_ctrl.clear) begin
            r_w <= '0;
            r_a <= '0;
        end else if (i_ctrl.scan || i_ctrl.rotate) begin
            r_w <= i_w;
            r_a <= a_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && (i_ctrl.entry_index == i_pos)) begin
            r_pat  <= i_ctrl.entry_byte;
            r_wild <= i_ctrl.entry_wild;
        end
    end

endmodule

### sv/wildcard_byte_pattern_scan.sv
`timescale 1ns / 1ps
// A scan transfer's result passes two register stages, the first stage (r_s1_*) and the
// output register, before it can transfer on o_res_valid; a stall can hold it there.
// Throughput: one item (load or scan) per cycle while o_in_ready is high. Writing
// pattern_length starts a realignment of the window chain; no item is taken meanwhile.
// Reset (i_rst_n, synchronous, active low) clears the window, counters and skip_count and
// sets pattern_length to 1; pattern entries hold undefined data until loaded.

module wildcard_byte_pattern_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  wbps_pkg::t_scan_item          i_in_item,
    // Result channel
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output wbps_pkg::t_scan_result        o_res_item,
    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [wbps_pkg::DATA_W-1:0]   pwdata,
    output logic [wbps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int PM   = wbps_pkg::PATTERN_MAX;
    localparam int OB   = wbps_pkg::OFFSET_BITS;
    localparam int LW   = wbps_pkg::LEN_W;
    localparam int SW   = wbps_pkg::SKIP_W;
    localparam int RBW  = $clog2(PM + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [SW-1:0]  r_skip;
    logic [LW-1:0]  r_len;
    logic           cfg_wr;
    wbps_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = wbps_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            wbps_pkg::REG_SKIP_COUNT:     prdata = wbps_pkg::DATA_W'(r_skip);
            wbps_pkg::REG_PATTERN_LENGTH: prdata = wbps_pkg::DATA_W'(r_len);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Realignment counter: after a length change, rotate the raw window once
    // round the chain and push its bytes, oldest first, into the aligned taps.
    // ------------------------------------------------------------------
    logic [RBW-1:0] r_rb_cnt;
    logic           busy;

    assign busy = (r_rb_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip   <= '0;
            r_len    <= LW'(1);
            r_rb_cnt <= '0;
        end else begin
            if (cfg_wr && (cfg_idx == wbps_pkg::REG_PATTERN_LENGTH)) begin
                r_rb_cnt <= RBW'(PM);
            end else if (busy) begin
                r_rb_cnt <= r_rb_cnt - RBW'(1);
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    wbps_pkg::REG_SKIP_COUNT: begin
                        r_skip <= pwdata[SW-1:0];
                    end
                    wbps_pkg::REG_PATTERN_LENGTH: begin
                        r_len <= pwdata[LW-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshakes and pipeline control
    // ------------------------------------------------------------------
    logic           in_xfer;
    logic           scan_xfer;
    logic           load_xfer;
    logic           out_free;
    logic           s1_go;
    logic           s1_free;
    logic           s1_sel;
    logic           s1_produce;

    logic           r_s1_valid;
    logic           r_s1_hit;
    logic           r_s1_last;
    logic [OB-1:0]  r_s1_off;

    logic [SW-1:0]  r_seen;
    logic           r_reported;
    logic [OB-1:0]  r_count;

    logic           r_out_valid;
    wbps_pkg::t_scan_result r_out;

    assign out_free   = !r_out_valid || i_res_ready;
    // Select the match whose index equals skip_count; close an unmatched image
    assign s1_sel     = r_s1_hit && !r_reported && (r_seen == r_skip);
    assign s1_produce = s1_sel || (r_s1_last && !r_reported);
    assign s1_go      = !s1_produce || out_free;
    assign s1_free    = !r_s1_valid || s1_go;

    assign o_in_ready = s1_free && !busy;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign scan_xfer  = in_xfer && (i_in_item.opcode == wbps_pkg::OP_SCAN);
    assign load_xfer  = in_xfer && (i_in_item.opcode == wbps_pkg::OP_LOAD);

    // ------------------------------------------------------------------
    // Window chain
    // ------------------------------------------------------------------
    logic [LW-1:0]  len_act;
    wbps_pkg::t_cell_ctrl ctrl;
    logic [7:0]     w_chain [PM];
    logic [7:0]     a_chain [PM];
    logic [PM-1:0]  eq;
    logic           win_match;

    assign len_act = wbps_pkg::active_len(r_len);

    always_comb begin
        ctrl.scan        = scan_xfer;
        ctrl.clear       = scan_xfer && i_in_item.last_byte;
        ctrl.rotate      = busy;
        ctrl.len_m1      = wbps_pkg::IDX_W'(len_act - LW'(1));
        ctrl.feed        = busy ? w_chain[PM-1] : i_in_item.scan_byte;
        ctrl.load        = load_xfer;
        ctrl.entry_index = i_in_item.entry_index;
        ctrl.entry_byte  = i_in_item.entry_byte;
        ctrl.entry_wild  = i_in_item.entry_wild;
    end

    for (genvar j = 0; j < PM; j++) begin : g_cell
        logic [7:0] w_in;
        logic [7:0] a_in;
        if (j == 0) begin : g_first
            assign w_in = ctrl.feed;
        end else begin : g_mid
            assign w_in = w_chain[j-1];
        end
        if (j == PM - 1) begin : g_last
            assign a_in = '0;
        end else begin : g_inner
            assign a_in = a_chain[j+1];
        end
        wbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (wbps_pkg::IDX_W'(j)),
            .i_ctrl  (ctrl),
            .i_w     (w_in),
            .i_a     (a_in),
            .o_w     (w_chain[j]),
            .o_a     (a_chain[j]),
            .o_eq    (eq[j])
        );
    end

    assign win_match = &eq;

    // ------------------------------------------------------------------
    // Byte counter and first stage
    // ------------------------------------------------------------------
    logic [OB-1:0]  n_count;
    logic           cnt_ok;

    assign n_count = r_count + OB'(1);
    // No match until pattern_length bytes have come since the scan began
    assign cnt_ok  = (n_count >= OB'(len_act));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (scan_xfer) begin
                r_count    <= i_in_item.last_byte ? '0 : n_count;
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_xfer) begin
            r_s1_hit  <= win_match && cnt_ok;
            r_s1_last <= i_in_item.last_byte;
            r_s1_off  <= n_count - OB'(len_act);
        end
    end

    // ------------------------------------------------------------------
    // Match selection: count skipped matches, hold off after a report,
    // and drop all scan state on the last byte.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (r_s1_valid && s1_go) begin
            if (r_s1_last) begin
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else if (r_s1_hit && !r_reported) begin
                if (s1_sel) begin
                    r_reported <= 1'b1;
                end else begin
                    r_seen <= r_seen + SW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_produce && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_produce && out_free) begin
            r_out.found        <= s1_sel;
            r_out.match_offset <= s1_sel ? r_s1_off : '0;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_item  = r_out;

endmodule
